@@ hw/rtl/psu_pkg.sv @@
// Package with shared constants, register codes and CORDIC tables for the particle shape update.
`default_nettype none
package psu_pkg;
  localparam int MaxPointsDef = 64;
  localparam int CordicStepsDef = 16;

  localparam logic [2:0] RegStartCx = 3'd0;
  localparam logic [2:0] RegStartCy = 3'd1;
  localparam logic [2:0] RegHSpeed = 3'd2;
  localparam logic [2:0] RegStartVs = 3'd3;
  localparam logic [2:0] RegSpin = 3'd4;
  localparam logic [2:0] RegGravity = 3'd5;
  localparam logic [2:0] RegScale = 3'd6;
  localparam logic [2:0] RegLife = 3'd7;

  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [35:0] GainQ30 = 36'sd652032874;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sh03243F6A8;
      5'd1: r = 36'sh01DAC6705;
      5'd2: r = 36'sh00FADBAFC;
      5'd3: r = 36'sh007F56EA6;
      5'd4: r = 36'sh003FEAB76;
      5'd5: r = 36'sh001FFD55B;
      5'd6: r = 36'sh000FFFAAA;
      5'd7: r = 36'sh0007FFF55;
      5'd8: r = 36'sh0003FFFEA;
      5'd9: r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/psu_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module psu_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/psu_cordic.sv @@
// Iterative CORDIC that turns an angle into rounded Q24 cosine and sine.
`default_nettype none
module psu_cordic import psu_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [35:0]  theta_i,
  output logic                     done_o,
  output logic signed [35:0]       cos_o,
  output logic signed [35:0]       sin_o
);
  localparam int StepW = $clog2(CordicSteps + 1);
  logic signed [35:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [StepW-1:0] i_q, i_d;
  logic busy_q, busy_d, fold_q, fold_d, done_d;
  logic signed [35:0] xs, ys, xf, yf;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q;
    fold_d = fold_q; done_d = 1'b0;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    if (start_i) begin
      fold_d = theta_i > HalfPiQ30;
      z_d = fold_d ? theta_i - PiQ30 : theta_i;
      x_d = GainQ30; y_d = '0; i_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atan_q30(5'(i_q));
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atan_q30(5'(i_q));
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  assign xf = fold_q ? -x_q : x_q;
  assign yf = fold_q ? -y_q : y_q;
  assign cos_o = (xf + 36'sd32) >>> 6;
  assign sin_o = (yf + 36'sd32) >>> 6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; i_q <= '0; fold_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_o <= done_d; i_q <= i_d; fold_q <= fold_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/particle_shape_update_top.sv @@
// Top level of the particle shape update: registers, sequencer and shared multiplier.
//
// A load transaction writes one outline point and leaves the block idle; index zero also
// restarts centre, vertical speed and life from the registers. A tick transaction is
// processed by a sequencer around one shared signed 36x36 multiplier and one iterative
// CORDIC unit. A tick first sets up life, angle, CORDIC, gravity and the two move offsets,
// and then, for each point, does the RAM read and its data step, six multiplies for
// rotation and scaling, write-back and the output transaction, which waits while the
// output is stalled. The multiplier sets the pace.
// Output transactions wait on out_stall_i without losing anything. The input is not
// accepted while a tick is in progress.
`default_nettype none
module particle_shape_update_top import psu_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [5:0]         point_index_i,
  input  wire logic signed [31:0] load_x_i,
  input  wire logic signed [31:0] load_y_i,
  input  wire logic               load_last_i,
  input  wire logic [15:0]        time_step_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [5:0]              out_index_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_center_x_o,
  output logic signed [31:0]      out_center_y_o,
  output logic                    expired_o,
  output logic                    out_last_o
);
  localparam int AddrW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StAngle = 5'd1;
  localparam logic [4:0] StCordic = 5'd2;
  localparam logic [4:0] StGrav = 5'd3;
  localparam logic [4:0] StHs = 5'd4;
  localparam logic [4:0] StVs = 5'd5;
  localparam logic [4:0] StRead = 5'd6;
  localparam logic [4:0] StData = 5'd7;
  localparam logic [4:0] StM1 = 5'd8;
  localparam logic [4:0] StM2 = 5'd9;
  localparam logic [4:0] StM3 = 5'd10;
  localparam logic [4:0] StM4 = 5'd11;
  localparam logic [4:0] StRot = 5'd12;
  localparam logic [4:0] StS1 = 5'd13;
  localparam logic [4:0] StS2 = 5'd14;
  localparam logic [4:0] StFin = 5'd15;
  localparam logic [4:0] StOut = 5'd16;
  localparam logic [4:0] StAngle2 = 5'd17;

  // Configuration registers.
  logic signed [31:0] start_cx_q, start_cy_q, hspeed_q, start_vs_q;
  logic [17:0] spin_q;
  logic [30:0] gravity_q;
  logic [16:0] scale_q;
  logic [23:0] start_life_q;

  // Particle state.
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d, vs_q, vs_d;
  logic [23:0] life_q, life_d;
  logic [CntW-1:0] count_q, count_d;

  logic [4:0] st_q, st_d;
  logic [AddrW-1:0] pt_q, pt_d;
  logic [15:0] dt_q, dt_d;
  logic signed [35:0] cos_q, cos_d, sin_q, sin_d;
  logic signed [31:0] ddx_q, ddx_d, ddy_q, ddy_d;
  logic signed [71:0] acc_q, acc_d;
  logic signed [63:0] p_q;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic signed [31:0] ocx_q, ocy_q;
  logic out_valid_q, out_valid_d;
  logic out_last_q, out_last_d;

  // Shared multiplier operands.
  logic signed [35:0] ma, mb;
  logic signed [71:0] mp;
  assign mp = ma * mb;

  // RAM ports.
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0] ram_wdata, ram_rdata;
  psu_ram #(.Width(64), .Depth(MAX_POINTS)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic cordic_start, cordic_done;
  logic signed [35:0] c_cos, c_sin;
  psu_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cordic_start), .theta_i(acc_q[35:0]),
    .done_o(cordic_done), .cos_o(c_cos), .sin_o(c_sin)
  );

  logic in_acc;
  assign in_stall_o = (st_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (st_q == StIdle);

  logic signed [71:0] rnd24, rnd16;
  logic signed [63:0] gsum;
  always_comb begin
    st_d = st_q; pt_d = pt_q; dt_d = dt_q; cos_d = cos_q; sin_d = sin_q;
    ddx_d = ddx_q; ddy_d = ddy_q; acc_d = acc_q;
    px_d = px_q; py_d = py_q; cx_d = cx_q; cy_d = cy_q; vs_d = vs_q;
    life_d = life_q; count_d = count_q; out_valid_d = out_valid_q; out_last_d = out_last_q;
    ma = '0; mb = '0; ram_we = 1'b0; ram_addr = pt_q; ram_wdata = {py_q, px_q};
    cordic_start = 1'b0;
    rnd24 = (acc_q + (72'sd1 <<< 23)) >>> 24;
    rnd16 = (72'(p_q) + 72'sd32768) >>> 16;
    gsum = '0;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          if (!kind_i) begin
            if (32'(point_index_i) < MAX_POINTS) begin
              ram_we = 1'b1;
              ram_addr = AddrW'(point_index_i);
              ram_wdata = {load_y_i, load_x_i};
              if (point_index_i == '0) begin
                cx_d = start_cx_q; cy_d = start_cy_q; vs_d = start_vs_q;
                life_d = start_life_q;
              end
              if (load_last_i) count_d = CntW'(32'(point_index_i) + 1);
            end
          end else begin
            dt_d = time_step_i;
            life_d = (life_q > 24'(time_step_i)) ? life_q - 24'(time_step_i) : '0;
            st_d = StAngle;
          end
        end
      end
      StAngle: begin
        ma = 36'(dt_q); mb = 36'(spin_q);
        acc_d = mp >>> 2;
        st_d = StAngle2;
      end
      StAngle2: begin
        cordic_start = 1'b1;
        st_d = StCordic;
      end
      StCordic: begin
        if (cordic_done) begin
          cos_d = c_cos; sin_d = c_sin; st_d = StGrav;
        end
      end
      StGrav: begin
        ma = 36'(gravity_q); mb = 36'(dt_q);
        gsum = 64'(vs_q) - 64'((mp + 72'sd32768) >>> 16);
        vs_d = sat32(gsum);
        st_d = StHs;
      end
      StHs: begin
        ma = 36'(hspeed_q); mb = 36'(dt_q);
        ddx_d = 32'((mp + 72'sd32768) >>> 16);
        st_d = StVs;
      end
      StVs: begin
        ma = 36'(vs_q); mb = 36'(dt_q);
        ddy_d = 32'((mp + 72'sd32768) >>> 16);
        pt_d = '0;
        st_d = (count_q == '0) ? StFin : StRead;
      end
      StRead: st_d = StData;
      StData: st_d = StM1;
      // Differences are held as 33-bit values inside the 36-bit operands.
      StM1: begin
        ma = 36'(64'($signed(ram_rdata[31:0])) - 64'(cx_q)); mb = cos_q;
        acc_d = mp; st_d = StM2;
      end
      StM2: begin
        ma = 36'(64'($signed(ram_rdata[63:32])) - 64'(cy_q)); mb = sin_q;
        acc_d = acc_q - mp; st_d = StM3;
      end
      StM3: begin
        px_d = sat32(64'(cx_q) + 64'(rnd24));
        ma = 36'(64'($signed(ram_rdata[31:0])) - 64'(cx_q)); mb = sin_q;
        acc_d = mp; st_d = StM4;
      end
      StM4: begin
        ma = 36'(64'($signed(ram_rdata[63:32])) - 64'(cy_q)); mb = cos_q;
        acc_d = acc_q + mp; st_d = StRot;
      end
      StRot: begin
        py_d = sat32(64'(cy_q) + 64'(rnd24));
        ma = 36'(64'(px_q) - 64'(cx_q)); mb = 36'(scale_q);
        st_d = StS1;
      end
      StS1: begin
        px_d = sat32(sat32(64'(cx_q) + 64'(rnd16)) + 64'(ddx_q));
        ma = 36'(64'(py_q) - 64'(cy_q)); mb = 36'(scale_q);
        st_d = StS2;
      end
      StS2: begin
        py_d = sat32(sat32(64'(cy_q) + 64'(rnd16)) + 64'(ddy_q));
        st_d = StFin;
      end
      StFin: begin
        if (count_q == '0) begin
          cx_d = sat32(64'(cx_q) + 64'(ddx_q));
          cy_d = sat32(64'(cy_q) + 64'(ddy_q));
          st_d = StIdle;
        end else begin
          ram_we = 1'b1;
          out_valid_d = 1'b1;
          out_last_d = (CntW'(pt_q) + 1'b1 == count_q);
          st_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q) begin
          if (out_last_q) begin
            cx_d = sat32(64'(cx_q) + 64'(ddx_q));
            cy_d = sat32(64'(cy_q) + 64'(ddy_q));
            st_d = StIdle;
          end else begin
            pt_d = pt_q + 1'b1;
            ram_addr = pt_q + 1'b1;
            st_d = StRead;
          end
        end
      end
      default: st_d = StIdle;
    endcase
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  // Centre as seen by emitted points already includes this tick's move.
  always_ff @(posedge clk_i) begin
    if (st_q == StFin) begin
      ocx_q <= sat32(64'(cx_q) + 64'(ddx_q));
      ocy_q <= sat32(64'(cy_q) + 64'(ddy_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cx_q <= '0; start_cy_q <= '0; hspeed_q <= '0; start_vs_q <= '0;
      spin_q <= '0; gravity_q <= 31'd65536000; scale_q <= 17'd65536;
      start_life_q <= 24'd65536;
      cx_q <= '0; cy_q <= '0; vs_q <= '0; life_q <= '0; count_q <= '0;
      st_q <= StIdle; out_valid_q <= 1'b0; out_last_q <= 1'b0; pt_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegStartCx: start_cx_q <= cfg_data_i;
          RegStartCy: start_cy_q <= cfg_data_i;
          RegHSpeed: hspeed_q <= cfg_data_i;
          RegStartVs: start_vs_q <= cfg_data_i;
          RegSpin: spin_q <= cfg_data_i[17:0];
          RegGravity: gravity_q <= cfg_data_i[30:0];
          RegScale: scale_q <= cfg_data_i[16:0];
          RegLife: start_life_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      cx_q <= cx_d; cy_q <= cy_d; vs_q <= vs_d; life_q <= life_d; count_q <= count_d;
      st_q <= st_d; out_valid_q <= out_valid_d; out_last_q <= out_last_d; pt_q <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d; cos_q <= cos_d; sin_q <= sin_d; ddx_q <= ddx_d; ddy_q <= ddy_d;
    acc_q <= acc_d; px_q <= px_d; py_q <= py_d;
    p_q <= mp[63:0];
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = 6'(pt_q);
  assign out_x_o = px_q;
  assign out_y_o = py_q;
  assign out_center_x_o = ocx_q;
  assign out_center_y_o = ocy_q;
  assign expired_o = (life_q == '0);
  assign out_last_o = out_last_q;
endmodule
`default_nettype wire

@@ hw/rtl/psu_checker.sv @@
// Port-level checker for the particle shape update, bound to the top level.
`default_nettype none
module psu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic kind_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic out_last_o,
  input wire logic cfg_ready_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output dropped under stall");
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("output while idle");
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !kind_i |=> !in_stall_o) else $error("load held block");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o) else $error("config ready while busy");
endmodule

bind particle_shape_update_top psu_checker u_psu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .kind_i(kind_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .out_last_o(out_last_o), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire

@@ verif/particle_shape_update_checker.sv @@
// Checker for the particle shape update: predicts each outline point and compares the output.
module particle_shape_update_checker import psu_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               kind_i,
  input  wire logic [5:0]         point_index_i,
  input  wire logic signed [31:0] load_x_i,
  input  wire logic signed [31:0] load_y_i,
  input  wire logic               load_last_i,
  input  wire logic [15:0]        time_step_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [5:0]         out_index_i,
  input  wire logic signed [31:0] out_x_i,
  input  wire logic signed [31:0] out_y_i,
  input  wire logic signed [31:0] out_center_x_i,
  input  wire logic signed [31:0] out_center_y_i,
  input  wire logic               expired_i,
  input  wire logic               out_last_i,
  output int                      pending_o,
  output int                      errors_o
);
  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               expired;
    logic               last;
  } point_t;

  point_t      point_q[$];
  logic [31:0] reg_val[8];
  longint      pt_x[MaxPointsDef];
  longint      pt_y[MaxPointsDef];
  longint      cen_x, cen_y, vert_speed;
  longint      life;
  int          n_points;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [31:0] reg_mask(logic [2:0] idx);
    case (idx)
      RegSpin:    return 32'h0003FFFF;
      RegGravity: return 32'h7FFFFFFF;
      RegScale:   return 32'h0001FFFF;
      RegLife:    return 32'h00FFFFFF;
      default:    return 32'hFFFFFFFF;
    endcase
  endfunction

  // Cosine and sine of the angle in Q24, by an iterative CORDIC pass in Q30.
  task automatic rotation_terms(input longint theta, output longint c, output longint s);
    longint x, y, z, nx, step;
    bit     fold;
    x = 64'sd652032874;
    y = 0;
    fold = theta > 64'sd1686629713;
    z = fold ? theta - 64'sd3373259426 : theta;
    for (int i = 0; i < CordicStepsDef && i < 24; i++) begin
      step = longint'(atan_q30(5'(i)));
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - step;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + step;
      end
      x = nx;
    end
    if (fold) begin
      x = -x;
      y = -y;
    end
    c = round_shift(x, 6);
    s = round_shift(y, 6);
  endtask

  task automatic advance_tick(input longint dt);
    longint c, s, scl, dx, dy, ddx, ddy;
    point_t p;
    life = (life > dt) ? life - dt : 0;
    rotation_terms((dt * longint'(reg_val[RegSpin])) >>> 2, c, s);
    scl = longint'(reg_val[RegScale]);
    for (int i = 0; i < n_points; i++) begin
      dx = pt_x[i] - cen_x;
      dy = pt_y[i] - cen_y;
      pt_x[i] = clamp32(cen_x + round_shift(dx * c - dy * s, 24));
      pt_y[i] = clamp32(cen_y + round_shift(dx * s + dy * c, 24));
      dx = pt_x[i] - cen_x;
      dy = pt_y[i] - cen_y;
      pt_x[i] = clamp32(cen_x + round_shift(dx * scl, 16));
      pt_y[i] = clamp32(cen_y + round_shift(dy * scl, 16));
    end
    vert_speed = clamp32(vert_speed - round_shift(longint'(reg_val[RegGravity]) * dt, 16));
    ddx = round_shift(sx32(reg_val[RegHSpeed]) * dt, 16);
    ddy = round_shift(vert_speed * dt, 16);
    for (int i = 0; i < n_points; i++) begin
      pt_x[i] = clamp32(pt_x[i] + ddx);
      pt_y[i] = clamp32(pt_y[i] + ddy);
    end
    cen_x = clamp32(cen_x + ddx);
    cen_y = clamp32(cen_y + ddy);
    for (int i = 0; i < n_points; i++) begin
      p.index = 6'(i);
      p.x = 32'(pt_x[i]);
      p.y = 32'(pt_y[i]);
      p.cx = 32'(cen_x);
      p.cy = 32'(cen_y);
      p.expired = (life == 0);
      p.last = (i + 1 == n_points);
      point_q.push_back(p);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t p;
    if (!rst_ni) begin
      reg_val[RegStartCx] <= 0;
      reg_val[RegStartCy] <= 0;
      reg_val[RegHSpeed] <= 0;
      reg_val[RegStartVs] <= 0;
      reg_val[RegSpin] <= 0;
      reg_val[RegGravity] <= 32'd65536000;
      reg_val[RegScale] <= 32'd65536;
      reg_val[RegLife] <= 32'd65536;
      cen_x = 0;
      cen_y = 0;
      vert_speed = 0;
      life = 0;
      n_points = 0;
      point_q.delete();
      errors_o = 0;
      for (int i = 0; i < MaxPointsDef; i++) begin
        pt_x[i] = 0;
        pt_y[i] = 0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        reg_val[cfg_index_i] <= cfg_data_i & reg_mask(cfg_index_i);
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i) begin
          advance_tick(longint'(time_step_i));
        end else begin
          pt_x[point_index_i] = longint'(load_x_i);
          pt_y[point_index_i] = longint'(load_y_i);
          if (point_index_i == 0) begin
            cen_x = sx32(reg_val[RegStartCx]);
            cen_y = sx32(reg_val[RegStartCy]);
            vert_speed = sx32(reg_val[RegStartVs]);
            life = longint'(reg_val[RegLife]);
          end
          if (load_last_i) n_points = int'(point_index_i) + 1;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point, actual index %h", $time, out_index_i);
          errors_o++;
        end else begin
          p = point_q.pop_front();
          compare_field("out_index", 32'(p.index), 32'(out_index_i));
          compare_field("out_x", p.x, out_x_i);
          compare_field("out_y", p.y, out_y_i);
          compare_field("out_center_x", p.cx, out_center_x_i);
          compare_field("out_center_y", p.cy, out_center_y_i);
          compare_field("expired", 32'(p.expired), 32'(expired_i));
          compare_field("out_last", 32'(p.last), 32'(out_last_i));
        end
      end
    end
    pending_o = point_q.size();
  end
endmodule

@@ verif/tb_particle_shape_update_top.sv @@
// Testbench top for the particle shape update: stimulus, stall generation and verdict.
module tb_particle_shape_update_top import psu_pkg::*;;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = RegStartCx;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = 1'b0;
  logic [5:0]         point_index_i = '0;
  logic signed [31:0] load_x_i = '0;
  logic signed [31:0] load_y_i = '0;
  logic               load_last_i = 1'b0;
  logic [15:0]        time_step_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         out_index_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_center_x_o;
  logic signed [31:0] out_center_y_o;
  logic               expired_o;
  logic               out_last_o;

  int  points_pending;
  int  mismatch_count;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  drain_left = 0;
  bit  send_eager = 1'b0;  // sender issues back-to-back transactions
  bit  drain_eager = 1'b0; // receiver never stalls
  bit  slot_loaded[64];
  int  shape_size = 0;

  // The clock: 10 time units per period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  particle_shape_update_top dut (.*);

  particle_shape_update_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .point_index_i, .load_x_i, .load_y_i,
    .load_last_i, .time_step_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_index_i(out_index_o), .out_x_i(out_x_o), .out_y_i(out_y_o),
    .out_center_x_i(out_center_x_o), .out_center_y_i(out_center_y_o),
    .expired_i(expired_o), .out_last_i(out_last_o),
    .pending_o(points_pending), .errors_o(mismatch_count)
  );

  // The receiver stalls for a fresh random number of cycles after each output transaction,
  // unless the current phase asks it to take everything at once.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      drain_left = drain_eager ? 0 : $urandom_range(0, 19);
      out_stall_i <= (drain_left != 0);
    end else if (drain_left > 0) begin
      drain_left--;
      out_stall_i <= (drain_left != 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog. The slowest correct run is far below this, even with every point stalled.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 6000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one transaction on the input channel, after a random gap unless sending eagerly,
  // and holds it until taken. The stall seen at the falling edge is what the next rising edge will act on.
  task automatic send_item(bit kind, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           bit last, logic [15:0] dt);
    int  gap;
    bit  stalled;
    gap = send_eager ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    point_index_i <= idx;
    load_x_i <= x;
    load_y_i <= y;
    load_last_i <= last;
    time_step_i <= dt;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items_sent++;
    if (!kind) begin
      slot_loaded[idx] = 1'b1;
      if (last) shape_size = int'(idx) + 1;
    end
  endtask

  task automatic load_point(logic [5:0] idx, logic [31:0] x, logic [31:0] y, bit last);
    send_item(1'b0, idx, x, y, last, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] dt);
    send_item(1'b1, 6'($urandom), $urandom, $urandom, 1'($urandom), dt);
  endtask

  // Waits until every predicted point has come out, then lets the block finish any tick that
  // produces nothing.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    bit ready;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    cfg_valid_i <= 1'b0;
  endtask

  // A register value: the bottom or top of its range now and then, otherwise random.
  function automatic logic [31:0] pick_reg(logic [31:0] mask, bit signed_reg);
    case ($urandom_range(0, 5))
      0: return signed_reg ? 32'h80000000 : 32'h0;
      1: return signed_reg ? 32'h7FFFFFFF : mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // Coordinates are modest half the time so that shapes survive several ticks, with full-range
  // and saturating values mixed in.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF);
    endcase
  endfunction

  // Every register is written in each phase. Centres and speeds are kept small in most
  // phases, the growth factor near one, so that points are not all pinned at the rails.
  task automatic configure_phase();
    bit wild;
    wild = ($urandom_range(0, 3) == 0);
    write_reg(RegStartCx, wild ? pick_reg(32'hFFFFFFFF, 1'b1) : pick_coord());
    write_reg(RegStartCy, wild ? pick_reg(32'hFFFFFFFF, 1'b1) : pick_coord());
    write_reg(RegHSpeed, wild ? pick_reg(32'hFFFFFFFF, 1'b1) : pick_coord());
    write_reg(RegStartVs, wild ? pick_reg(32'hFFFFFFFF, 1'b1) : pick_coord());
    write_reg(RegSpin, pick_reg(32'h0003FFFF, 1'b0));
    write_reg(RegGravity, wild ? pick_reg(32'h7FFFFFFF, 1'b0) : $urandom_range(0, 32'h3FFFFFF));
    write_reg(RegScale, wild ? pick_reg(32'h0001FFFF, 1'b0) : $urandom_range(60000, 70000));
    write_reg(RegLife, pick_reg(32'h00FFFFFF, 1'b0));
  endtask

  // A tick may only run once every slot below the point count holds a loaded point.
  function automatic bit shape_complete();
    for (int i = 0; i < shape_size; i++) if (!slot_loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int  n;
    int  full_shapes;
    int  idx;
    bit  all_below;
    full_shapes = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, on the reset register values first: ticks with no points, then
    // one- and two-point shapes at the coordinate extremes with the largest time step and with
    // a time step of zero or one.
    send_eager = 1'b1;
    drain_eager = 1'b1;
    tick(16'hFFFF);
    tick(16'h0000);
    load_point(6'd0, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    tick(16'hFFFF);
    tick(16'h0000);
    load_point(6'd1, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    tick(16'h0001);
    tick(16'hFFFF);
    wait_idle();
    write_reg(RegSpin, 32'h0003FFFF);
    write_reg(RegScale, 32'h0001FFFF);
    write_reg(RegLife, 32'h00FFFFFF);
    write_reg(RegGravity, 32'h7FFFFFFF);
    write_reg(RegStartVs, 32'h80000000);
    write_reg(RegHSpeed, 32'h7FFFFFFF);
    write_reg(RegStartCx, 32'h80000000);
    write_reg(RegStartCy, 32'h7FFFFFFF);
    load_point(6'd0, 32'h00010000, 32'hFFFF0000, 1'b0);
    load_point(6'd1, 32'h0, 32'h0, 1'b1);
    tick(16'hFFFF);
    tick(16'h8000);
    wait_idle();
    write_reg(RegSpin, 32'h0);
    write_reg(RegScale, 32'h0);
    write_reg(RegLife, 32'h0);
    write_reg(RegGravity, 32'h0);
    load_point(6'd0, 32'h12345678, 32'hEDCBA987, 1'b1);
    tick(16'h4000);
    tick(16'h0000);

    // Random part: phases of fresh settings, a well-formed shape, then ticks with a few
    // stray loads mixed in.
    while (items_sent < 470) begin
      wait_idle();
      configure_phase();
      send_eager = ($urandom_range(0, 3) == 0);
      drain_eager = ($urandom_range(0, 3) == 0);
      if (full_shapes < 3 && $urandom_range(0, 9) == 0) begin
        n = 64;
        full_shapes++;
      end else begin
        n = $urandom_range(1, 8);
      end
      for (int i = 0; i < n; i++) load_point(6'(i), pick_coord(), pick_coord(), i == n - 1);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 5) == 0) begin
          idx = $urandom_range(0, 63);
          all_below = 1'b1;
          for (int i = 0; i < idx; i++) if (!slot_loaded[i]) all_below = 1'b0;
          load_point(6'(idx), pick_coord(), pick_coord(), all_below && $urandom_range(0, 1));
        end
        // Now and then the sender holds back until every point so far has come out.
        if ($urandom_range(0, 9) == 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (points_pending != 0) @(posedge clk_i);
        end
        if (shape_complete()) tick(16'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/psu_pkg.sv
hw/rtl/psu_ram.sv
hw/rtl/psu_cordic.sv
hw/rtl/particle_shape_update_top.sv
hw/rtl/psu_checker.sv
verif/particle_shape_update_checker.sv
verif/tb_particle_shape_update_top.sv
